>>> design/esc_pkg.sv
// Shared constants, command/status types and month table for the seconds-to-calendar block.
package esc_pkg;

  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_DAY  = 24 * 3600;
  localparam int unsigned EPOCH_YEAR    = 2000;
  localparam int unsigned DAYS_LEAP     = 366;
  localparam int unsigned DAYS_COMMON   = 365;
  localparam int unsigned LEAP_CYCLE    = 400;
  localparam int unsigned CENTURY       = 100;

  // Floor division by a constant: shift out the divisor's power-of-two factor, then
  // take (x * RECIP) >> SHIFT. Exact over the range each step sees.
  // Day:    x = seconds within month >> 7 (below 2**15), odd factor 675.
  // Hour:   x = seconds within day >> 4 (below 5400), odd factor 225.
  // Minute: x = seconds within hour >> 2 (below 900), odd factor 15.
  localparam int unsigned DAY_RECIP  = 49711;
  localparam int unsigned DAY_SHIFT  = 25;
  localparam int unsigned HOUR_RECIP = 9321;
  localparam int unsigned HOUR_SHIFT = 21;
  localparam int unsigned MIN_RECIP  = 1093;
  localparam int unsigned MIN_SHIFT  = 14;

  // Seconds in the longest month need this many bits.
  localparam int MONTH_SECS_W = 22;

  // Packed result: year, month, day, hour, minute, second, zero padded to bytes.
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int FIELDS_W = YEAR_W + MONTH_W + DAY_W + HOUR_W + MINUTE_W + SECOND_W;
  localparam int OUT_W    = ((FIELDS_W + 7) / 8) * 8;

  localparam logic [3:0] LAST_MONTH_IDX = 4'd11;

  typedef struct packed {
    logic start;
    logic year_step;
    logic month_step;
    logic day_div;
    logic day_sub;
    logic hour_div;
    logic hour_sub;
    logic min_div;
    logic min_sub;
    logic capture;
  } esc_cmd_t;

  typedef struct packed {
    logic year_fit;
    logic month_fit;
  } esc_status_t;

  // Length of month idx (0 = January) in seconds.
  function automatic logic [MONTH_SECS_W-1:0] month_secs(input logic leap,
                                                         input logic [3:0] idx);
    logic [MONTH_SECS_W-1:0] len;
    unique case (idx)
      4'd1: begin
        len = leap ? MONTH_SECS_W'(29 * SECS_PER_DAY) : MONTH_SECS_W'(28 * SECS_PER_DAY);
      end
      4'd3, 4'd5, 4'd8, 4'd10: len = MONTH_SECS_W'(30 * SECS_PER_DAY);
      default:                 len = MONTH_SECS_W'(31 * SECS_PER_DAY);
    endcase
    return len;
  endfunction

endpackage

>>> design/epoch_seconds_to_calendar_unit.sv
// Top level of the seconds-since-2000 to Gregorian date and time converter.
//
// Usage: present a count of seconds since 2000-01-01 00:00:00 on the input
// stream (in_tvalid/in_tready/in_tdata); one item comes back on the output
// stream (out_tvalid/out_tready/out_tdata) with year, month, day, hour,
// minute and second. Items are converted one at a time.
// Steps: a year loop that takes off one year of seconds per step, a month
// search that takes off one month per step, six steps to split off day,
// hour, minute and second by constant reciprocal multiplication, and one
// step to load the output register; the year loop dominates. The next
// item is taken once the controller returns to idle after that load.
// in_tready is high only while the converter is idle. A finished item moves
// into the output register, so the next item is taken while the previous
// result still waits; if the receiver stalls and the register is still
// full, the converter holds its result and stops taking input.
// Reset (rst_n low, synchronous) returns the controller to idle and drops
// any pending output item.
module epoch_seconds_to_calendar_unit
  import esc_pkg::*;
#(
  parameter int SECONDS_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // fields from bit 0: seconds_count[SECONDS_WIDTH-1:0], zero padding
  input  logic [((SECONDS_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // fields from bit 0: year_out[11:0], month_out[15:12], day_out[20:16],
  // hour_out[25:21], minute_out[31:26], second_out[37:32], zero padding
  output logic [OUT_W-1:0]                      out_tdata
);

  esc_cmd_t    cmd;
  esc_status_t status;

  // Controller: walks the year, month and time phases and owns the handshakes.
  esc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // Datapath: only the low SECONDS_WIDTH bits of the count take part.
  esc_datapath #(
    .SW (SECONDS_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .in_seconds (in_tdata[SECONDS_WIDTH-1:0]),
    .cmd        (cmd),
    .status     (status),
    .out_data   (out_tdata)
  );

endmodule

>>> design/esc_datapath.sv
// Datapath: year and month reduction in seconds, constant-reciprocal splits and result register.
module esc_datapath
  import esc_pkg::*;
#(
  parameter int SW = 32
) (
  input  logic              clk,
  input  logic [SW-1:0]     in_seconds,
  input  esc_cmd_t          cmd,
  output esc_status_t       status,
  output logic [OUT_W-1:0]  out_data
);

  localparam int YW = (((SW - 24) > 11) ? (SW - 24) : 11) + 1;

  logic [SW-1:0]       sec_r;
  logic [YW-1:0]       year_r;
  logic [6:0]          mod100_r;
  logic [8:0]          mod400_r;
  logic [3:0]          m_r;
  logic [DAY_W-1:0]    day_r;
  logic [HOUR_W-1:0]   hour_r;
  logic [MINUTE_W-1:0] minute_r;
  logic [OUT_W-1:0]    out_r;

  logic                    leap;
  logic [SW-1:0]           year_secs;
  logic [MONTH_SECS_W-1:0] mon_secs;
  logic [30:0]             day_prod;
  logic [26:0]             hour_prod;
  logic [20:0]             min_prod;

  // Leap: divisible by 4, and not a century unless divisible by 400.
  assign leap      = (mod400_r[1:0] == 2'd0) && ((mod100_r != 7'd0) || (mod400_r == 9'd0));
  assign year_secs = leap ? SW'(DAYS_LEAP * SECS_PER_DAY) : SW'(DAYS_COMMON * SECS_PER_DAY);
  assign mon_secs  = month_secs(leap, m_r);

  // Quotients by 86400, 3600 and 60 of the remaining seconds.
  assign day_prod  = 31'(sec_r[21:7]) * 31'(DAY_RECIP);
  assign hour_prod = 27'(sec_r[16:4]) * 27'(HOUR_RECIP);
  assign min_prod  = 21'(sec_r[11:2]) * 21'(MIN_RECIP);

  assign status.year_fit  = (sec_r < year_secs);
  assign status.month_fit = (m_r == LAST_MONTH_IDX) || (sec_r < SW'(mon_secs));

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sec_r    <= in_seconds;
      year_r   <= YW'(EPOCH_YEAR);
      mod100_r <= 7'd0;
      mod400_r <= 9'd0;
      m_r      <= 4'd0;
    end else if (cmd.year_step) begin
      sec_r    <= sec_r - year_secs;
      year_r   <= year_r + YW'(1);
      mod100_r <= (mod100_r == 7'(CENTURY - 1)) ? 7'd0 : mod100_r + 7'd1;
      mod400_r <= (mod400_r == 9'(LEAP_CYCLE - 1)) ? 9'd0 : mod400_r + 9'd1;
    end else if (cmd.month_step) begin
      sec_r <= sec_r - SW'(mon_secs);
      m_r   <= m_r + 4'd1;
    end else if (cmd.day_div) begin
      day_r <= day_prod[DAY_SHIFT +: DAY_W];
    end else if (cmd.day_sub) begin
      sec_r <= sec_r - SW'(22'(day_r) * 22'(SECS_PER_DAY));
    end else if (cmd.hour_div) begin
      hour_r <= hour_prod[HOUR_SHIFT +: HOUR_W];
    end else if (cmd.hour_sub) begin
      sec_r <= sec_r - SW'(17'(hour_r) * 17'(SECS_PER_HOUR));
    end else if (cmd.min_div) begin
      minute_r <= min_prod[MIN_SHIFT +: MINUTE_W];
    end else if (cmd.min_sub) begin
      sec_r <= sec_r - SW'(12'(minute_r) * 12'(SECS_PER_MIN));
    end

    if (cmd.capture) begin
      out_r <= {(OUT_W-FIELDS_W)'(0), sec_r[SECOND_W-1:0], minute_r, hour_r,
                day_r + DAY_W'(1), m_r + 4'd1, year_r[YEAR_W-1:0]};
    end
  end

  assign out_data = out_r;

endmodule

>>> design/esc_ctrl.sv
// Controller: sequences the year loop, month search, time splits and output handshake.
module esc_ctrl
  import esc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  esc_status_t status,
  output esc_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_YEAR  = 4'd1;
  localparam logic [3:0] S_MONTH = 4'd2;
  localparam logic [3:0] S_DDIV  = 4'd3;
  localparam logic [3:0] S_DSUB  = 4'd4;
  localparam logic [3:0] S_HDIV  = 4'd5;
  localparam logic [3:0] S_HSUB  = 4'd6;
  localparam logic [3:0] S_MDIV  = 4'd7;
  localparam logic [3:0] S_MSUB  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.start = 1'b1;
          state_nxt = S_YEAR;
        end
      end
      S_YEAR: begin
        if (status.year_fit) begin
          state_nxt = S_MONTH;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      S_MONTH: begin
        if (status.month_fit) begin
          state_nxt = S_DDIV;
        end else begin
          cmd.month_step = 1'b1;
        end
      end
      S_DDIV: begin
        cmd.day_div = 1'b1;
        state_nxt   = S_DSUB;
      end
      S_DSUB: begin
        cmd.day_sub = 1'b1;
        state_nxt   = S_HDIV;
      end
      S_HDIV: begin
        cmd.hour_div = 1'b1;
        state_nxt    = S_HSUB;
      end
      S_HSUB: begin
        cmd.hour_sub = 1'b1;
        state_nxt    = S_MDIV;
      end
      S_MDIV: begin
        cmd.min_div = 1'b1;
        state_nxt   = S_MSUB;
      end
      S_MSUB: begin
        cmd.min_sub = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        // Hold the finished item until the output register is free.
        if (!out_valid_r || out_tready) begin
          cmd.capture = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.capture | (out_valid_r & ~out_tready);
  assign out_tvalid    = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> tb/epoch_seconds_to_calendar_unit_tb.sv
// Self-checking testbench for the seconds-since-2000 to calendar date and time converter.
module epoch_seconds_to_calendar_unit_tb
  import esc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Count width and the byte-padded input bus width that follows from it.
  localparam int SECS_W = 32;
  localparam int IN_W   = ((SECS_W + 7) / 8) * 8;

  // Bit positions of the result fields in out_tdata, lowest first.
  localparam int YEAR_LSB   = 0;
  localparam int MONTH_LSB  = YEAR_LSB + YEAR_W;
  localparam int DAY_LSB    = MONTH_LSB + MONTH_W;
  localparam int HOUR_LSB   = DAY_LSB + DAY_W;
  localparam int MINUTE_LSB = HOUR_LSB + HOUR_W;
  localparam int SECOND_LSB = MINUTE_LSB + MINUTE_W;

  // Drain time after the last phase, wider than the worst conversion.
  localparam int LATENCY_CYCLES = 250;
  // Long enough for the converter and its output register to fill up.
  localparam int HOLD_CYCLES    = 1000;
  localparam int HOLD_ITEMS     = 30;
  localparam int PHASE_ITEMS    = 180;
  localparam int HOURS_PER_DAY  = 24;
  localparam int LAST_MONTH     = 11;

  logic            clk;
  logic            rst_n;
  logic            in_tvalid;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata;   // bit 0 up: seconds_count
  logic            out_tvalid;
  logic            out_tready;
  // bit 0 up: year_out, month_out, day_out, hour_out, minute_out, second_out, padding
  logic [OUT_W-1:0] out_tdata;

  // Idling mix for the current phase, in percent of cycles.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit          hold_off_req;

  typedef struct {
    logic [SECS_W-1:0]   secs;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } date_t;

  // Gregorian rule: every fourth year, but centuries only every fourth century.
  function automatic bit is_leap(int unsigned y);
    return ((y % 4 == 0) && (y % CENTURY != 0)) || (y % LEAP_CYCLE == 0);
  endfunction

  // Length of month m, counted from 0 for January.
  function automatic int unsigned month_len(int unsigned m, bit leap);
    case (m)
      1:           return leap ? 29 : 28;
      3, 5, 8, 10: return 30;
      default:     return 31;
    endcase
  endfunction

  // Expected date and time of day for one seconds count.
  function automatic date_t seconds_to_date(logic [SECS_W-1:0] secs);
    date_t       d;
    int unsigned days;
    int unsigned yr;
    int unsigned mon;
    bit          leap;
    days = secs / SECS_PER_DAY;
    yr   = EPOCH_YEAR;
    leap = is_leap(yr);
    // Peel off whole years, then whole months.
    while (days >= (leap ? DAYS_LEAP : DAYS_COMMON)) begin
      days = days - (leap ? DAYS_LEAP : DAYS_COMMON);
      yr++;
      leap = is_leap(yr);
    end
    mon = 0;
    while (mon < LAST_MONTH && days >= month_len(mon, leap)) begin
      days = days - month_len(mon, leap);
      mon++;
    end
    d.secs   = secs;
    d.year   = YEAR_W'(yr);
    d.month  = MONTH_W'(mon + 1);
    d.day    = DAY_W'(days + 1);
    d.hour   = HOUR_W'((secs / SECS_PER_HOUR) % HOURS_PER_DAY);
    d.minute = MINUTE_W'((secs / SECS_PER_MIN) % SECS_PER_MIN);
    d.second = SECOND_W'(secs % SECS_PER_MIN);
    return d;
  endfunction

  // Seconds count for a calendar date and time, used to aim the stimulus.
  function automatic logic [SECS_W-1:0] stamp(int unsigned y, int unsigned mo, int unsigned dy,
                                               int unsigned h, int unsigned mi, int unsigned s);
    longint unsigned days;
    days = 0;
    for (int unsigned yy = EPOCH_YEAR; yy < y; yy++) begin
      days += is_leap(yy) ? DAYS_LEAP : DAYS_COMMON;
    end
    for (int unsigned mm = 0; mm + 1 < mo; mm++) begin
      days += month_len(mm, is_leap(y));
    end
    days += dy - 1;
    return SECS_W'(days * SECS_PER_DAY + h * SECS_PER_HOUR + mi * SECS_PER_MIN + s);
  endfunction

  // Random count: full range, or clustered around year and month starts, or a random date.
  function automatic logic [SECS_W-1:0] random_stamp();
    int unsigned y;
    int unsigned m;
    longint      base;
    longint      jitter;
    y = $urandom_range(2135, EPOCH_YEAR);
    m = $urandom_range(12, 1);
    case ($urandom_range(3))
      0: return SECS_W'($urandom());
      1: begin
        base   = stamp(y + 1, 1, 1, 0, 0, 0);
        jitter = longint'($urandom_range(4 * SECS_PER_DAY)) - longint'(2 * SECS_PER_DAY);
        return SECS_W'(base + jitter);
      end
      2: begin
        base   = stamp(y, $urandom_range(12, 2), 1, 0, 0, 0);
        jitter = longint'($urandom_range(2 * SECS_PER_DAY)) - longint'(SECS_PER_DAY);
        return SECS_W'(base + jitter);
      end
      default: begin
        return stamp(y, m, $urandom_range(month_len(m - 1, is_leap(y)), 1),
                     $urandom_range(HOURS_PER_DAY - 1), $urandom_range(SECS_PER_MIN - 1),
                     $urandom_range(SECS_PER_MIN - 1));
      end
    endcase
  endfunction

  // Holds the dates owed by the converter, oldest first, and checks them off.
  class calendar_check;
    date_t       dates_due[$];
    int unsigned items_taken;
    int unsigned dates_seen;
    int unsigned failures;

    function void note_input(logic [SECS_W-1:0] secs);
      dates_due.push_back(seconds_to_date(secs));
      items_taken++;
    endfunction

    function void check_field(string name, logic [SECS_W-1:0] secs,
                              int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s for %0d s: expected %0d, got %0d", name, secs, want, got);
        failures++;
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] word);
      date_t want;
      dates_seen++;
      if (dates_due.size() == 0) begin
        $error("result %h arrived with no item outstanding", word);
        failures++;
        return;
      end
      want = dates_due.pop_front();
      check_field("year_out",   want.secs, want.year,   word[YEAR_LSB +: YEAR_W]);
      check_field("month_out",  want.secs, want.month,  word[MONTH_LSB +: MONTH_W]);
      check_field("day_out",    want.secs, want.day,    word[DAY_LSB +: DAY_W]);
      check_field("hour_out",   want.secs, want.hour,   word[HOUR_LSB +: HOUR_W]);
      check_field("minute_out", want.secs, want.minute, word[MINUTE_LSB +: MINUTE_W]);
      check_field("second_out", want.secs, want.second, word[SECOND_LSB +: SECOND_W]);
    endfunction
  endclass

  calendar_check dates = new();

  epoch_seconds_to_calendar_unit #(
    .SECONDS_WIDTH(SECS_W)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up after far more time than the slowest correct run needs.
  initial begin
    #10ms;
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: stall at the phase's rate, or hold off for a long counted stretch on request.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Check every item the receiver takes. Inputs were sampled before the edge's updates.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      dates.check_result(out_tdata);
    end
  end

  // Offer one item, idling first at the phase's rate; return at the edge that takes it.
  // Valid stays high into the next item unless that item idles first.
  task automatic send_item(input logic [SECS_W-1:0] secs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'(secs);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    dates.note_input(secs);
  endtask

  // Drop valid and pause until every owed date has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (dates.dates_due.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input int unsigned n_items);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n_items) send_item(random_stamp());
    drain_results();
  endtask

  initial begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_req   = 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    rst_n     <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: range ends, day and month edges, leap days, year ends, skipped century leap.
    send_item('0);
    send_item('1);
    send_item(SECS_W'(SECS_PER_MIN - 1));
    send_item(SECS_W'(SECS_PER_DAY - 1));
    send_item(stamp(2000, 2, 28, 23, 59, 59));
    send_item(stamp(2000, 2, 29, 0, 0, 0));
    send_item(stamp(2000, 3, 1, 0, 0, 0));
    send_item(stamp(2000, 12, 31, 12, 0, 0));   // last day of a leap year
    send_item(stamp(2001, 1, 1, 0, 0, 0));
    send_item(stamp(2001, 12, 31, 23, 59, 59)); // last day of a common year
    send_item(stamp(2002, 1, 1, 0, 0, 0));
    send_item(stamp(2004, 2, 29, 6, 30, 15));
    send_item(stamp(2023, 10, 31, 23, 0, 1));
    send_item(stamp(2024, 7, 15, 12, 34, 56));
    send_item(stamp(2099, 12, 31, 23, 59, 59));
    send_item(stamp(2100, 2, 28, 23, 59, 59));
    send_item(stamp(2100, 3, 1, 0, 0, 0));      // 2100 has no February 29
    send_item(stamp(2100, 12, 31, 23, 59, 59));
    send_item(stamp(2101, 1, 1, 0, 0, 0));
    send_item(stamp(2135, 12, 31, 23, 59, 59));
    send_item(stamp(2136, 1, 1, 0, 0, 0));
    send_item(stamp(2136, 2, 7, 6, 28, 14));
    drain_results();

    // Hold the receiver off while items keep coming, so the converter backs up.
    hold_off_req = 1'b1;
    run_phase(0, 0, HOLD_ITEMS);

    run_phase(0, 0, PHASE_ITEMS);
    run_phase(59, 0, PHASE_ITEMS);
    run_phase(0, 59, PHASE_ITEMS);
    run_phase(38, 38, PHASE_ITEMS);

    repeat (LATENCY_CYCLES) @(posedge clk);

    $display("Converted %0d seconds counts (directed edges, a receiver hold-off,", dates.items_taken);
    $display("four idling mixes) and checked %0d dates.", dates.dates_seen);
    if (dates.failures == 0 && dates.dates_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
